FILE: design/differential_drive_odometry_unit_assert.svh
// Assertion macros used by the odometry top level.
// Depends on nothing; included by the top level.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define DDO_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("odometry check failed");

// Checks that a condition implies a consequence on the next edge.
`define DDO_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("odometry check failed");

`endif

FILE: design/ddo_pkg.sv
// Package for the differential-drive odometry unit: types and constants.
// Depends on nothing.
package ddo_pkg;

    localparam int CordicSteps = 30;
    localparam logic [31:0] CordicGainQ30 = 32'd652032874;
    localparam logic [19:0] UsPerSecond = 20'd1000000;

    localparam logic [1:0] RegKLeft  = 2'd0;
    localparam logic [1:0] RegKRight = 2'd1;
    localparam logic [1:0] RegKAngle = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [19:0] elapsed_us;
    } ddo_in_t;

    typedef struct packed {
        logic [47:0] pose_x;
        logic [47:0] pose_y;
        logic [23:0] heading;
        logic [31:0] speed_x;
        logic [31:0] speed_y;
        logic [31:0] turn_rate;
        logic [31:0] speed_left;
        logic [31:0] speed_right;
        logic        time_error;
    } ddo_out_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
                5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
                5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
                5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
                5'd20: r = 32'd651;       5'd21: r = 32'd325;
                5'd22: r = 32'd162;       5'd23: r = 32'd81;
                5'd24: r = 32'd40;        5'd25: r = 32'd20;
                5'd26: r = 32'd10;        5'd27: r = 32'd5;
                5'd28: r = 32'd2;         5'd29: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/ddo_stream_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; the payload type is a parameter.
interface ddo_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/differential_drive_odometry_unit.sv
// Top level of the differential-drive odometry unit: sequencer and shared datapath.
// Depends on ddo_pkg, ddo_stream_if and the assertion macro header.
//
// Usage: samples arrive on in_ch (mode, left_count, right_count, elapsed_us) and
// one pose/speed result per sample leaves on out_ch. Both channels transfer on a
// clock edge where valid and ready are high. Gains k_left, k_right and k_angle
// are written over the APB port (byte address 4*index); the user must write
// them only while the unit is idle, since the block itself does not enforce it.
// All products go through one 32x32 multiplier in two passes (low and high half
// of the multiplicand) plus a step to scale and sign the result. A reset-mode
// sample goes straight to the output step. An update sample takes five
// products, the load and 30 steps of the CORDIC rotator and the output step
// when elapsed_us is zero; otherwise five rates follow, each a product, a
// restoring division and a saturation step. One sample is in work at a time:
// in_ch.ready is high only when the unit is idle and the output register is
// empty, so the next sample can be taken the cycle after the result transfer.
// When the receiver stalls, the finished result stays in the output register
// and the unit holds further samples off. Reset clears the pose, the baselines
// and the gains to their defaults, and empties the output.
`include "differential_drive_odometry_unit_assert.svh"

module differential_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int HEADING_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    ddo_stream_if.sink   in_ch,
    ddo_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] StIdle   = 4'd0;
    localparam logic [3:0] StMulLo  = 4'd1;
    localparam logic [3:0] StMulHi  = 4'd2;
    localparam logic [3:0] StMulEnd = 4'd3;
    localparam logic [3:0] StCordA  = 4'd4;
    localparam logic [3:0] StCord   = 4'd5;
    localparam logic [3:0] StDiv    = 4'd6;
    localparam logic [3:0] StRateE  = 4'd7;
    localparam logic [3:0] StDone   = 4'd8;

    // Which product the shared multiplier is working on.
    localparam logic [2:0] MopDl   = 3'd0;
    localparam logic [2:0] MopDr   = 3'd1;
    localparam logic [2:0] MopAng  = 3'd2;
    localparam logic [2:0] MopX    = 3'd3;
    localparam logic [2:0] MopY    = 3'd4;
    localparam logic [2:0] MopRate = 3'd5;

    localparam logic [4:0] LastStep = 5'(CordicSteps - 1);
    localparam int HB = HEADING_BITS;

    logic [3:0] state_reg, state_next;
    logic [2:0] mop_reg;
    logic [23:0] k_left_reg, k_right_reg;
    logic [31:0] k_angle_reg;
    logic [COUNT_WIDTH-1:0] base_l_reg, base_r_reg;
    logic [COUNT_WIDTH-1:0] tick_l_reg, tick_r_reg;
    logic [47:0] pos_x_reg, pos_y_reg;
    logic [HB-1:0] head_reg;
    logic [19:0] el_reg;
    logic mode_reg;
    logic signed [63:0] dl_reg, dr_reg, dth_reg, dx_reg, dy_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic flip_reg;
    logic [4:0] step_reg;
    logic [2:0] rsel_reg;
    logic [95:0] acc_reg;
    // divider: the quotient bits shift in from the right as the dividend leaves
    logic [83:0] dvd_reg;
    logic [24:0] rem_reg;
    logic [6:0] dcnt_reg;
    logic [23:0] div_reg;
    logic neg_reg;
    logic [31:0] rate_reg [5];
    ddo_out_t out_reg;
    logic out_valid_reg;

    // shared unsigned 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [COUNT_WIDTH-1:0] cnt_l, cnt_r;
    logic signed [63:0] sum_w, diff_w, rate_src, op_src;
    logic [63:0] op_mag;
    logic [31:0] op_k;
    logic op_kneg, op_neg;
    logic [33:0] cx_abs, cy_abs;
    logic [63:0] p_full, q35, q36, p_sh35, p_sh36;
    logic f35, f36;
    logic [24:0] rem_try;
    logic [31:0] a32;
    logic a_flip;
    logic signed [33:0] sx, sy, atan_w, cx_nxt, cy_nxt, cz_nxt;
    logic accept_in, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept_in = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == StIdle) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            RegKLeft:  prdata = {8'd0, k_left_reg};
            RegKRight: prdata = {8'd0, k_right_reg};
            RegKAngle: prdata = k_angle_reg;
            default:   prdata = 32'd0;
        endcase
    end

    assign cnt_l = in_ch.data.left_count[COUNT_WIDTH-1:0];
    assign cnt_r = in_ch.data.right_count[COUNT_WIDTH-1:0];
    assign sum_w = dl_reg + dr_reg;
    assign diff_w = dr_reg - dl_reg;
    assign a32 = 32'(head_reg) << (32 - HB);
    assign a_flip = a32[31] ^ a32[30];

    // One CORDIC rotation step; the sign of the residual angle picks the direction.
    assign sx = cx_reg >>> step_reg;
    assign sy = cy_reg >>> step_reg;
    assign atan_w = 34'($signed({1'b0, atan_turn(step_reg)}));
    assign cx_nxt = cz_reg[33] ? cx_reg + sy : cx_reg - sy;
    assign cy_nxt = cz_reg[33] ? cy_reg - sx : cy_reg + sx;
    assign cz_nxt = cz_reg[33] ? cz_reg + atan_w : cz_reg - atan_w;

    always_comb
    begin
        unique case (rsel_reg)
            3'd0: rate_src = dx_reg;
            3'd1: rate_src = dy_reg;
            3'd2: rate_src = dth_reg;
            3'd3: rate_src = dl_reg;
            default: rate_src = dr_reg;
        endcase
    end

    assign cx_abs = cx_reg[33] ? -cx_reg : cx_reg;
    assign cy_abs = cy_reg[33] ? -cy_reg : cy_reg;

    // Operands of the product in work: a signed multiplicand and a magnitude
    // multiplier with its own sign.
    always_comb
    begin
        op_src = '0;
        op_k = '0;
        op_kneg = 1'b0;
        unique case (mop_reg)
            MopDl:
            begin
                op_src = 64'($signed(tick_l_reg));
                op_k = {8'd0, k_left_reg};
            end
            MopDr:
            begin
                op_src = 64'($signed(tick_r_reg));
                op_k = {8'd0, k_right_reg};
            end
            MopAng:
            begin
                op_src = diff_w;
                op_k = k_angle_reg;
            end
            MopX:
            begin
                op_src = sum_w;
                op_k = cx_abs[31:0];
                op_kneg = cx_reg[33];
            end
            MopY:
            begin
                op_src = sum_w;
                op_k = cy_abs[31:0];
                op_kneg = cy_reg[33];
            end
            default:
            begin
                op_src = rate_src;
                op_k = 32'(UsPerSecond);
            end
        endcase
    end

    assign op_mag = op_src[63] ? -op_src : op_src;
    assign op_neg = op_src[63] ^ op_kneg;
    assign mul_a = (state_reg == StMulHi) ? op_mag[63:32] : op_mag[31:0];
    assign mul_b = op_k;

    // Signed results of the finished product: unscaled, and floored after a
    // right shift by 35 or 36 (for negatives, -(q + 1) is ~q).
    assign p_full = op_neg ? -acc_reg[63:0] : acc_reg[63:0];
    assign q35 = 64'(acc_reg[95:35]);
    assign q36 = 64'(acc_reg[95:36]);
    assign f35 = |acc_reg[34:0];
    assign f36 = |acc_reg[35:0];
    assign p_sh35 = op_neg ? (f35 ? ~q35 : -q35) : q35;
    assign p_sh36 = op_neg ? (f36 ? ~q36 : -q36) : q36;

    assign rem_try = {rem_reg[23:0], dvd_reg[83]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle:   if (accept_in) state_next = in_ch.data.mode ? StDone : StMulLo;
            StMulLo:  state_next = StMulHi;
            StMulHi:  state_next = StMulEnd;
            StMulEnd:
            begin
                unique case (mop_reg)
                    MopAng:  state_next = StCordA;
                    MopY:    state_next = (el_reg == 20'd0) ? StDone : StMulLo;
                    MopRate: state_next = StDiv;
                    default: state_next = StMulLo;
                endcase
            end
            StCordA:  state_next = StCord;
            StCord:   if (step_reg == LastStep) state_next = StMulLo;
            StDiv:    if (dcnt_reg == 7'd83) state_next = StRateE;
            StRateE:  state_next = (rsel_reg == 3'd4) ? StDone : StMulLo;
            StDone:   state_next = StIdle;
            default:  state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            mop_reg <= MopDl;
            k_left_reg <= 24'd1048576;
            k_right_reg <= 24'd1048576;
            k_angle_reg <= 32'd65536;
            base_l_reg <= '0;
            base_r_reg <= '0;
            tick_l_reg <= '0;
            tick_r_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            head_reg <= '0;
            el_reg <= '0;
            mode_reg <= 1'b0;
            dl_reg <= '0;
            dr_reg <= '0;
            dth_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            flip_reg <= 1'b0;
            step_reg <= '0;
            rsel_reg <= '0;
            acc_reg <= '0;
            dvd_reg <= '0;
            rem_reg <= '0;
            dcnt_reg <= '0;
            div_reg <= '0;
            neg_reg <= 1'b0;
            for (int k = 0; k < 5; k++) rate_reg[k] <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    RegKLeft:  k_left_reg <= pwdata[23:0];
                    RegKRight: k_right_reg <= pwdata[23:0];
                    RegKAngle: k_angle_reg <= pwdata;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                StIdle:
                    if (accept_in)
                    begin
                        el_reg <= in_ch.data.elapsed_us;
                        mode_reg <= in_ch.data.mode;
                        base_l_reg <= cnt_l;
                        base_r_reg <= cnt_r;
                        // tick differences wrap at the counter width
                        tick_l_reg <= cnt_l - base_l_reg;
                        tick_r_reg <= cnt_r - base_r_reg;
                        mop_reg <= MopDl;
                        for (int k = 0; k < 5; k++) rate_reg[k] <= '0;
                        if (in_ch.data.mode)
                        begin
                            pos_x_reg <= '0;
                            pos_y_reg <= '0;
                            head_reg <= '0;
                        end
                    end
                StMulLo:
                    acc_reg <= {32'd0, mul_p};
                StMulHi:
                    acc_reg[95:32] <= acc_reg[95:32] + mul_p;
                StMulEnd:
                begin
                    unique case (mop_reg)
                        MopDl:
                        begin
                            dl_reg <= p_full;
                            mop_reg <= MopDr;
                        end
                        MopDr:
                        begin
                            dr_reg <= p_full;
                            mop_reg <= MopAng;
                        end
                        MopAng:
                        begin
                            dth_reg <= p_sh36;
                            head_reg <= head_reg + p_sh36[HB-1:0];
                            mop_reg <= MopX;
                        end
                        MopX:
                        begin
                            dx_reg <= p_sh35;
                            pos_x_reg <= pos_x_reg + p_sh35[47:0];
                            mop_reg <= MopY;
                        end
                        MopY:
                        begin
                            dy_reg <= p_sh35;
                            pos_y_reg <= pos_y_reg + p_sh35[47:0];
                            mop_reg <= MopRate;
                            rsel_reg <= '0;
                        end
                        default:
                        begin
                            // load the divider with |value| * 1e6
                            neg_reg <= op_neg;
                            dvd_reg <= acc_reg[83:0];
                            rem_reg <= '0;
                            dcnt_reg <= '0;
                            div_reg <= (rsel_reg >= 3'd3) ? {el_reg, 4'd0} : {4'd0, el_reg};
                        end
                    endcase
                end
                StCordA:
                begin
                    // Fold the second and third quadrants onto the fourth and first.
                    flip_reg <= a_flip;
                    cz_reg <= 34'($signed(a32 ^ {a_flip, 31'd0}));
                    cx_reg <= 34'($signed({1'b0, CordicGainQ30}));
                    cy_reg <= '0;
                    step_reg <= '0;
                end
                StCord:
                begin
                    cz_reg <= cz_nxt;
                    if (step_reg == LastStep)
                    begin
                        step_reg <= '0;
                        cx_reg <= flip_reg ? -cx_nxt : cx_nxt;
                        cy_reg <= flip_reg ? -cy_nxt : cy_nxt;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                        cx_reg <= cx_nxt;
                        cy_reg <= cy_nxt;
                    end
                end
                StDiv:
                begin
                    // restoring division, one quotient bit per cycle
                    if (rem_try >= {1'b0, div_reg})
                    begin
                        rem_reg <= rem_try - {1'b0, div_reg};
                        dvd_reg <= {dvd_reg[82:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try;
                        dvd_reg <= {dvd_reg[82:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 7'd1;
                end
                StRateE:
                begin
                    if (neg_reg)
                        rate_reg[rsel_reg] <= (dvd_reg > 84'd2147483648) ? 32'h8000_0000
                                              : 32'(-dvd_reg[31:0]);
                    else
                        rate_reg[rsel_reg] <= (dvd_reg > 84'd2147483647) ? 32'h7FFF_FFFF
                                              : dvd_reg[31:0];
                    rsel_reg <= rsel_reg + 3'd1;
                end
                StDone:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.pose_x <= pos_x_reg;
                    out_reg.pose_y <= pos_y_reg;
                    out_reg.heading <= 24'(head_reg);
                    out_reg.speed_x <= rate_reg[0];
                    out_reg.speed_y <= rate_reg[1];
                    out_reg.turn_rate <= rate_reg[2];
                    out_reg.speed_left <= rate_reg[3];
                    out_reg.speed_right <= rate_reg[4];
                    out_reg.time_error <= (el_reg == 20'd0) && !mode_reg;
                end
                default: ;
            endcase
        end
    end

    `DDO_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != StIdle, !in_ch.ready)
    `DDO_ASSERT_NEXT(a_done_sets_valid, clk, rst_n, state_reg == StDone, out_ch.valid)
    `DDO_ASSERT_IMP(a_cord_step, clk, rst_n, state_reg == StCord, step_reg <= LastStep)

endmodule

FILE: test/tb_differential_drive_odometry_unit.sv
// Testbench for the differential-drive odometry unit: random and directed samples,
// checked against a built-in pose predictor. Depends on ddo_pkg, ddo_stream_if
// and the unit's RTL.
`timescale 1ns / 1ps

module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ddo_stream_if #(.payload_t(ddo_in_t))  in_ch ();
    ddo_stream_if #(.payload_t(ddo_out_t)) out_ch ();

    differential_drive_odometry_unit dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Arctangent of 2^-i in units of 2^32 per turn, one entry per rotation step.
    localparam longint AtanStep [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1
    };

    // Predictor copy of the gains and of the odometry state.
    logic [23:0] gain_left = 24'd1048576;
    logic [23:0] gain_right = 24'd1048576;
    logic [31:0] gain_angle = 32'd65536;
    logic [31:0] last_left = '0;
    logic [31:0] last_right = '0;
    logic [47:0] pos_x = '0;
    logic [47:0] pos_y = '0;
    logic [23:0] hdg = '0;

    ddo_in_t  pending_samples[$];
    ddo_out_t expected_poses[$];

    int  errors = 0;
    int  samples_accepted = 0;
    int  poses_checked = 0;
    int  zero_time_samples = 0;
    int  rebase_samples = 0;
    bit  idling_on = 1'b1;

    // Generator-side copy of the last counts sent, so that most samples move
    // the wheels by a plausible amount.
    logic [31:0] gen_left = '0;
    logic [31:0] gen_right = '0;

    // floor(a * b / 2^sh), low 64 bits, with a full-width product.
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = pa * pb;
        p = p >>> sh;
        return p[63:0];
    endfunction

    // v * 1e6 / div, truncated toward zero and saturated to 32-bit signed.
    function automatic logic [31:0] per_second(longint v, logic [63:0] div);
        logic [127:0] m, q;
        m = (v < 0) ? 128'(-v) : 128'(v);
        q = m * 128'd1000000 / 128'(div);
        if (v < 0)
            return (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    // Rotation-based cosine and sine in Q1.30 of a 24-bit binary angle.
    task automatic heading_cos_sin(input logic [23:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, tx, ty;
        a = {ang, 8'h00};
        flip = a[31] ^ a[30];
        if (flip)
            a[31] = ~a[31];
        z = longint'(signed'(a));
        x = longint'(652032874);
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            tx = y >>> i;
            ty = x >>> i;
            if (z >= 0)
            begin
                x = x - tx; y = y + ty; z = z - AtanStep[i];
            end
            else
            begin
                x = x + tx; y = y - ty; z = z + AtanStep[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advances the predicted pose by one sample and returns the expected result.
    task automatic advance_pose(input ddo_in_t smp, output ddo_out_t r);
        int     tick_l, tick_r;
        longint dl, dr, dth, c, s, dx, dy;
        r = '0;
        if (smp.mode)
        begin
            last_left = smp.left_count;
            last_right = smp.right_count;
            pos_x = '0;
            pos_y = '0;
            hdg = '0;
        end
        else
        begin
            tick_l = smp.left_count - last_left;
            tick_r = smp.right_count - last_right;
            dl = longint'(tick_l) * longint'(gain_left);
            dr = longint'(tick_r) * longint'(gain_right);
            last_left = smp.left_count;
            last_right = smp.right_count;
            dth = scaled_product(dr - dl, longint'(gain_angle), 36);
            hdg = hdg + dth[23:0];
            heading_cos_sin(hdg, c, s);
            dx = scaled_product(dl + dr, c, 35);
            dy = scaled_product(dl + dr, s, 35);
            pos_x = pos_x + dx[47:0];
            pos_y = pos_y + dy[47:0];
            if (smp.elapsed_us == '0)
                r.time_error = 1'b1;
            else
            begin
                r.speed_x = per_second(dx, 64'(smp.elapsed_us));
                r.speed_y = per_second(dy, 64'(smp.elapsed_us));
                r.turn_rate = per_second(dth, 64'(smp.elapsed_us));
                r.speed_left = per_second(dl, 64'(smp.elapsed_us) * 16);
                r.speed_right = per_second(dr, 64'(smp.elapsed_us) * 16);
            end
        end
        r.pose_x = pos_x;
        r.pose_y = pos_y;
        r.heading = hdg;
    endtask

    function automatic void check_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Driver: holds a sample until it is taken, then offers the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_samples.size() > 0 && !(idling_on && $urandom_range(99) < 15))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_samples.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // The receiver stalls at random while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !(idling_on && $urandom_range(99) < 15);
    end

    // Monitor: predicts on each accepted sample, checks each accepted result.
    always @(posedge clk)
    begin
        ddo_out_t want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            samples_accepted++;
            if (in_ch.data.mode)
                rebase_samples++;
            else if (in_ch.data.elapsed_us == '0)
                zero_time_samples++;
            advance_pose(in_ch.data, want);
            expected_poses.push_back(want);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_poses.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with no sample pending, actual %h",
                         $time, out_ch.data);
            end
            else
            begin
                want = expected_poses.pop_front();
                poses_checked++;
                check_field("pose_x", 64'(want.pose_x), 64'(out_ch.data.pose_x));
                check_field("pose_y", 64'(want.pose_y), 64'(out_ch.data.pose_y));
                check_field("heading", 64'(want.heading), 64'(out_ch.data.heading));
                check_field("speed_x", 64'(want.speed_x), 64'(out_ch.data.speed_x));
                check_field("speed_y", 64'(want.speed_y), 64'(out_ch.data.speed_y));
                check_field("turn_rate", 64'(want.turn_rate), 64'(out_ch.data.turn_rate));
                check_field("speed_left", 64'(want.speed_left),
                            64'(out_ch.data.speed_left));
                check_field("speed_right", 64'(want.speed_right),
                            64'(out_ch.data.speed_right));
                check_field("time_error", 64'(want.time_error),
                            64'(out_ch.data.time_error));
            end
        end
    end

    task automatic queue_sample(logic mode, logic [31:0] lc, logic [31:0] rc,
                                logic [19:0] el);
        ddo_in_t smp;
        smp.mode = mode;
        smp.left_count = lc;
        smp.right_count = rc;
        smp.elapsed_us = el;
        gen_left = lc;
        gen_right = rc;
        pending_samples.push_back(smp);
    endtask

    // Mostly small wheel motions at a normal sample period; some full-range
    // counts, odd periods, zero periods and rebase samples mixed in.
    task automatic queue_random_sample();
        logic [31:0] lc, rc;
        logic [19:0] el;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            lc = gen_left + $urandom_range(4000) - 2000;
            rc = gen_right + $urandom_range(4000) - 2000;
        end
        else if (pick < 85)
        begin
            lc = gen_left + $urandom_range(400000) - 200000;
            rc = gen_right + $urandom_range(400000) - 200000;
        end
        else
        begin
            lc = $urandom;
            rc = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 70)
            el = 20'($urandom_range(20000, 5000));
        else if (pick < 78)
            el = '0;
        else if (pick < 85)
            el = 20'($urandom_range(3, 1));
        else
            el = 20'($urandom);
        queue_sample($urandom_range(99) < 4, lc, rc, el);
    endtask

    // Waits until every queued sample has been taken and answered, then lets
    // the unit settle for longer than an update takes.
    task automatic drain();
        while (pending_samples.size() > 0 || in_ch.valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle; the predictor follows.
    task automatic write_gain(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegKLeft:  gain_left = value[23:0];
            RegKRight: gain_right = value[23:0];
            RegKAngle: gain_angle = value;
            default: ;
        endcase
    endtask

    initial
    begin
        logic [31:0] gl [6], gr [6], ga [6];
        gl = '{32'hFFFFFF, 32'd0, 32'd1048576, 32'd0, 32'd65536, 32'd1};
        gr = '{32'hFFFFFF, 32'd0, 32'd1048576, 32'hFFFFFF, 32'd917504, 32'd1};
        ga = '{32'hFFFFFFFF, 32'd0, 32'd65536, 32'd12345678, 32'd3000000, 32'd1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset gains: rebase, straight run, spin,
        // count extremes and wrapping differences, zero and longest periods.
        queue_sample(1'b1, 32'd1000, 32'd2000, 20'd10000);
        queue_sample(1'b0, 32'd1100, 32'd2100, 20'd10000);
        queue_sample(1'b0, 32'd1000, 32'd2200, 20'd10000);
        queue_sample(1'b0, 32'd1000, 32'd2200, 20'd0);
        queue_sample(1'b0, 32'd5000, 32'd1000, 20'hFFFFF);
        queue_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 20'd1);
        queue_sample(1'b0, 32'h80000000, 32'h7FFFFFFF, 20'd1);
        queue_sample(1'b0, 32'hFFFFFFFF, 32'h00000000, 20'd0);
        queue_sample(1'b0, 32'h00000000, 32'hFFFFFFFF, 20'hFFFFF);
        queue_sample(1'b1, 32'hFFFFFFFF, 32'h80000000, 20'hFFFFF);
        queue_sample(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'd1);
        queue_sample(1'b1, 32'h0, 32'h0, 20'd0);
        for (int i = 0; i < 8; i++)
            queue_sample(1'b0, gen_left + 32'd400000, gen_right + 32'd900000, 20'd10000);
        drain();

        // Random phases, one per gain setting; the second runs with no idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_gain(RegKLeft, gl[ph]);
            write_gain(RegKRight, gr[ph]);
            write_gain(RegKAngle, ga[ph]);
            idling_on = (ph != 1);
            for (int n = 0; n < 222; n++)
                queue_random_sample();
            drain();
        end

        $display("Covered %0d samples (%0d rebase, %0d zero-period), %0d results checked,",
                 samples_accepted, rebase_samples, zero_time_samples, poses_checked);
        $display("over six gain settings including all-zero and all-maximum gains.");
        if (errors == 0 && expected_poses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Timeout far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/ddo_pkg.sv
design/ddo_stream_if.sv
design/differential_drive_odometry_unit.sv
test/tb_differential_drive_odometry_unit.sv
